FILE: sv/tpr_pkg.sv
// Shared constants, types and functions for the tile plane pixel renderer.
package tpr_pkg;

    localparam int VRAM_BYTES    = 65536;
    localparam int VRAM_AW       = $clog2(VRAM_BYTES);
    localparam int SCREEN_WIDTH  = 256;
    localparam int SCREEN_HEIGHT = 192;
    localparam int VBLANK_LINE   = 192;
    localparam int SUMY_W        = 10;

    localparam int MAP_INIT_BASE    = 32'h1000;
    localparam int MAP_INIT_ENTRIES = 768;
    localparam int TEST_TILE_BYTES  = 128;

    localparam logic [7:0] PORT_STATUS  = 8'h10;
    localparam logic [7:0] PORT_CONTROL = 8'h11;
    localparam logic [7:0] PORT_SCROLLX = 8'h12;
    localparam logic [7:0] PORT_SCROLLY = 8'h13;
    localparam logic [7:0] PORT_MAPBASE = 8'h16;
    localparam logic [7:0] PORT_PATBASE = 8'h18;
    localparam logic [7:0] NOT_MAPPED   = 8'hFF;

    localparam logic RESULT_BYTE  = 1'b0;
    localparam logic RESULT_PIXEL = 1'b1;

    typedef enum logic [2:0] {
        CMD_PORT_RD   = 3'd0,
        CMD_PORT_WR   = 3'd1,
        CMD_VRAM_WR   = 3'd2,
        CMD_VRAM_RD   = 3'd3,
        CMD_SCANLINE  = 3'd4,
        CMD_PIXEL     = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_VRD,
        ST_WRAP,
        ST_MAP_LO,
        ST_MAP_HI,
        ST_PAT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [7:0] control;
        logic [7:0] scroll_h;
        logic [7:0] scroll_v;
        logic [7:0] map_page;
        logic [7:0] pattern_page;
    } regset_t;

    function automatic logic [31:0] palette(input logic [3:0] nib);
        logic [31:0] c;
        case (nib)
            4'd0:  c = 32'hFF000000;
            4'd1:  c = 32'hFF0000AA;
            4'd2:  c = 32'hFF00AA00;
            4'd3:  c = 32'hFF00AAAA;
            4'd4:  c = 32'hFFAA0000;
            4'd5:  c = 32'hFFAA00AA;
            4'd6:  c = 32'hFFAA5500;
            4'd7:  c = 32'hFFAAAAAA;
            4'd8:  c = 32'hFF555555;
            4'd9:  c = 32'hFF5555FF;
            4'd10: c = 32'hFF55FF55;
            4'd11: c = 32'hFF55FFFF;
            4'd12: c = 32'hFFFF5555;
            4'd13: c = 32'hFFFF55FF;
            4'd14: c = 32'hFFFFFF55;
            default: c = 32'hFFFFFFFF;
        endcase
        return c;
    endfunction

    // Power-up contents: four test tiles, then the tilemap laid over them
    // (the tilemap wins where a small memory folds the two together).
    function automatic logic [7:0] init_byte(input logic [VRAM_AW-1:0] a);
        logic [VRAM_AW-1:0] off;
        logic [7:0]         v;
        off = a - VRAM_AW'(MAP_INIT_BASE);
        v = 8'h00;
        if (int'(off) < 2 * MAP_INIT_ENTRIES) begin
            v = off[0] ? 8'h00 : {6'd0, off[2:1]};
        end else if (int'(a) < TEST_TILE_BYTES) begin
            case (a[6:5])
                2'd0: v = 8'hFF;
                2'd1: v = a[2] ? 8'hF0 : 8'h0F;
                2'd2: v = 8'h0C;
                default: v = a[2] ? 8'hAA : 8'h00;
            endcase
        end
        return v;
    endfunction

endpackage

FILE: sv/tile_plane_pixel_renderer.sv
// Top level of the tile plane pixel renderer: control sequencer around the video RAM.
//
// Input channel s_*: one transaction per command. s_tuser carries the command,
// s_tdata the operands. Port writes, video RAM writes and begin-scanline events
// give no result. Port reads give a result through ST_EMIT and the output
// register; video RAM reads pass through ST_VRD before ST_EMIT.
// A pixel request on a visible line runs the vertical scroll wrap (at most two
// compare-subtract steps), then three dependent byte reads (tilemap low, tilemap
// high, pattern) through the single video RAM port, and gives its result; no
// new command is taken until the pixel is through. With the display disabled
// the black pixel skips the wrap and the reads.
// Invisible lines give no result.
// Result channel m_*: one output register. The next command is taken while a
// result waits; if a new result is ready while the register is still full and
// m_tready is low, the sequencer holds it and takes no input until it moves.
// Reset (aresetn low, synchronous) restores all display registers and starts
// a fill pass that writes the power-up contents into the video RAM, one byte a
// cycle over all VRAM_BYTES (65536) addresses, during which s_tready stays low.
module tile_plane_pixel_renderer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] port_number, [15:8] data_byte, [31:16] vram_address,
    // [40:32] line_number, [48:41] column, [55:49] zero
    input  logic [55:0] s_tdata,
    // [2:0] cmd
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] read_byte, [39:8] pixel_argb, [47:40] pixel_column
    output logic [47:0] m_tdata,
    // [0] result_kind
    output logic        m_tuser
);

    localparam int AW = tpr_pkg::VRAM_AW;
    localparam int SUMY_W_L = tpr_pkg::SUMY_W;

    tpr_pkg::state_t  state_reg, state_next;
    tpr_pkg::regset_t pend_reg, pend_next, act_reg, act_next;
    logic             vblank_reg, vblank_next;
    logic [AW-1:0]    cnt_reg, cnt_next;
    logic [SUMY_W_L-1:0] sumy_reg, sumy_next;
    logic [7:0]       gx_reg, gx_next;
    logic [7:0]       col_reg, col_next;
    logic [7:0]       lo_reg, lo_next;
    logic             rkind_reg, rkind_next;
    logic [7:0]       rbyte_reg, rbyte_next;
    logic [31:0]      rargb_reg, rargb_next;
    logic             mvalid_reg, mvalid_next;
    logic [47:0]      mdata_reg, mdata_next;
    logic             muser_reg, muser_next;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata, ram_rdata;

    logic [7:0]  in_port, in_byte, in_col;
    logic [15:0] in_addr;
    logic [8:0]  in_line;
    logic [2:0]  in_cmd;
    logic        accept;
    logic [7:0]  gy, port_val;
    logic [17:0] map_addr;
    logic [19:0] pat_addr;
    logic [9:0]  tile;
    logic [3:0]  nib;

    tpr_ram #(.WIDTH(8), .DEPTH(tpr_pkg::VRAM_BYTES)) u_vram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign in_port = s_tdata[7:0];
    assign in_byte = s_tdata[15:8];
    assign in_addr = s_tdata[31:16];
    assign in_line = s_tdata[40:32];
    assign in_col  = s_tdata[48:41];
    assign in_cmd  = s_tuser;

    assign s_tready = (state_reg == tpr_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

    // gy is valid once the wrap loop has finished
    assign gy       = sumy_reg[7:0];
    assign map_addr = {act_reg.map_page, 10'd0} + {7'd0, gy[7:3], gx_reg[7:3], 1'b0};
    assign tile     = {ram_rdata[1:0], lo_reg};
    assign pat_addr = {act_reg.pattern_page, 12'd0} >> 2;
    assign nib      = gx_reg[0] ? ram_rdata[3:0] : ram_rdata[7:4];

    always_comb begin
        case (in_port)
            tpr_pkg::PORT_STATUS:  port_val = {7'd0, vblank_reg};
            tpr_pkg::PORT_CONTROL: port_val = pend_reg.control;
            tpr_pkg::PORT_SCROLLX: port_val = pend_reg.scroll_h;
            tpr_pkg::PORT_SCROLLY: port_val = pend_reg.scroll_v;
            tpr_pkg::PORT_MAPBASE: port_val = pend_reg.map_page;
            tpr_pkg::PORT_PATBASE: port_val = pend_reg.pattern_page;
            default:               port_val = tpr_pkg::NOT_MAPPED;
        endcase
    end

    always_comb begin
        logic [19:0] pa;
        state_next  = state_reg;
        pend_next   = pend_reg;
        act_next    = act_reg;
        vblank_next = vblank_reg;
        cnt_next    = cnt_reg;
        sumy_next   = sumy_reg;
        gx_next     = gx_reg;
        col_next    = col_reg;
        lo_next     = lo_reg;
        rkind_next  = rkind_reg;
        rbyte_next  = rbyte_reg;
        rargb_next  = rargb_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        muser_next  = muser_reg;
        ram_we      = 1'b0;
        ram_addr    = map_addr[AW-1:0];
        ram_wdata   = in_byte;
        pa = pat_addr + {5'd0, tile, 5'd0} + {15'd0, gy[2:0], 2'd0}
             + {18'd0, gx_reg[2:1]};

        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end

        unique case (state_reg)
            tpr_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = cnt_reg;
                ram_wdata = tpr_pkg::init_byte(cnt_reg);
                cnt_next  = cnt_reg + AW'(1);
                if (cnt_reg == AW'(tpr_pkg::VRAM_BYTES - 1)) begin
                    state_next = tpr_pkg::ST_IDLE;
                end
            end
            tpr_pkg::ST_IDLE: begin
                ram_addr = in_addr[AW-1:0];
                if (accept) begin
                    case (in_cmd)
                        tpr_pkg::CMD_PORT_RD: begin
                            rkind_next = tpr_pkg::RESULT_BYTE;
                            rbyte_next = port_val;
                            state_next = tpr_pkg::ST_EMIT;
                        end
                        tpr_pkg::CMD_PORT_WR: begin
                            case (in_port)
                                tpr_pkg::PORT_CONTROL: pend_next.control      = in_byte;
                                tpr_pkg::PORT_SCROLLX: pend_next.scroll_h     = in_byte;
                                tpr_pkg::PORT_SCROLLY: pend_next.scroll_v     = in_byte;
                                tpr_pkg::PORT_MAPBASE: pend_next.map_page     = in_byte;
                                tpr_pkg::PORT_PATBASE: pend_next.pattern_page = in_byte;
                                default: ;
                            endcase
                        end
                        tpr_pkg::CMD_VRAM_WR: begin
                            ram_we = 1'b1;
                        end
                        tpr_pkg::CMD_VRAM_RD: begin
                            rkind_next = tpr_pkg::RESULT_BYTE;
                            state_next = tpr_pkg::ST_VRD;
                        end
                        tpr_pkg::CMD_SCANLINE: begin
                            act_next = pend_reg;
                            if (in_line == 9'(tpr_pkg::VBLANK_LINE)) begin
                                vblank_next = 1'b1;
                            end else if (in_line == 9'd0) begin
                                vblank_next = 1'b0;
                            end
                        end
                        tpr_pkg::CMD_PIXEL: begin
                            rkind_next = tpr_pkg::RESULT_PIXEL;
                            rbyte_next = 8'd0;
                            col_next   = in_col;
                            gx_next    = in_col + act_reg.scroll_h;
                            sumy_next  = SUMY_W_L'(in_line) + SUMY_W_L'(act_reg.scroll_v);
                            if (int'(in_line) >= tpr_pkg::SCREEN_HEIGHT) begin
                                state_next = tpr_pkg::ST_IDLE;
                            end else if (!act_reg.control[0]) begin
                                rargb_next = tpr_pkg::palette(4'd0);
                                state_next = tpr_pkg::ST_EMIT;
                            end else begin
                                state_next = tpr_pkg::ST_WRAP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            tpr_pkg::ST_VRD: begin
                rbyte_next = ram_rdata;
                state_next = tpr_pkg::ST_EMIT;
            end
            tpr_pkg::ST_WRAP: begin
                // one subtract per cycle until y is inside the screen
                if (int'(sumy_reg) >= tpr_pkg::SCREEN_HEIGHT) begin
                    sumy_next = sumy_reg - SUMY_W_L'(tpr_pkg::SCREEN_HEIGHT);
                end else begin
                    state_next = tpr_pkg::ST_MAP_LO;
                end
            end
            tpr_pkg::ST_MAP_LO: begin
                lo_next    = ram_rdata;
                ram_addr   = map_addr[AW-1:0] + AW'(1);
                state_next = tpr_pkg::ST_MAP_HI;
            end
            tpr_pkg::ST_MAP_HI: begin
                ram_addr   = pa[AW-1:0];
                state_next = tpr_pkg::ST_PAT;
            end
            tpr_pkg::ST_PAT: begin
                rargb_next = tpr_pkg::palette(nib);
                state_next = tpr_pkg::ST_EMIT;
            end
            tpr_pkg::ST_EMIT: begin
                if (!mvalid_reg || m_tready) begin
                    mvalid_next = 1'b1;
                    muser_next  = rkind_reg;
                    if (rkind_reg == tpr_pkg::RESULT_PIXEL) begin
                        mdata_next = {col_reg, rargb_reg, 8'd0};
                    end else begin
                        mdata_next = {40'd0, rbyte_reg};
                    end
                    state_next = tpr_pkg::ST_IDLE;
                end
            end
            default: state_next = tpr_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= tpr_pkg::ST_CLEAR;
            cnt_reg    <= '0;
            pend_reg   <= '{control: 8'd1, scroll_h: 8'd0, scroll_v: 8'd0,
                            map_page: 8'd4, pattern_page: 8'd0};
            act_reg    <= '{control: 8'd1, scroll_h: 8'd0, scroll_v: 8'd0,
                            map_page: 8'd4, pattern_page: 8'd0};
            vblank_reg <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            pend_reg   <= pend_next;
            act_reg    <= act_next;
            vblank_reg <= vblank_next;
            mvalid_reg <= mvalid_next;
        end
        sumy_reg  <= sumy_next;
        gx_reg    <= gx_next;
        col_reg   <= col_next;
        lo_reg    <= lo_next;
        rkind_reg <= rkind_next;
        rbyte_reg <= rbyte_next;
        rargb_reg <= rargb_next;
        mdata_reg <= mdata_next;
        muser_reg <= muser_next;
    end

endmodule

FILE: sv/tpr_ram.sv
// Generic single-port synchronous RAM with registered read.
module tpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule
